// ===== hdl/gsdc_pkg.sv =====
// Package: shared types, register map and reset values for the gripper stall detector.
`timescale 1ns / 1ps

package gsdc_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SAMPLES   = 3'd0;
    localparam logic [2:0] REG_ZERO      = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_SETTLE    = 3'd3;
    localparam logic [2:0] REG_TIMEOUT   = 3'd4;

    // Reset values
    localparam logic [7:0]  RST_SAMPLES   = 8'd200;
    localparam logic [13:0] RST_ZERO      = 14'd8852;
    localparam logic [13:0] RST_THRESHOLD = 14'd499;
    localparam logic [15:0] RST_SETTLE    = 16'd500;
    localparam logic [15:0] RST_TIMEOUT   = 16'd5000;

    localparam logic [15:0] MS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_START  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PRE    = 2'd1,
        PH_SETTLE = 2'd2,
        PH_MON    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  samples_per_average;
        logic [13:0] zero_offset_x16;
        logic [13:0] stall_threshold_x16;
        logic [15:0] settle_ms;
        logic [15:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic status;
        logic done_res;
        logic busy_res;
        logic drive_b;
        logic drive_a;
        logic motor_enable;
    } res_t;

endpackage

// ===== hdl/gsdc_regs.sv =====
// APB configuration register file for the gripper stall detector.
`timescale 1ns / 1ps

module gsdc_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gsdc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gsdc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gsdc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output gsdc_pkg::cfg_t                  cfg
);
    import gsdc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_average <= RST_SAMPLES;
            cfg_reg.zero_offset_x16     <= RST_ZERO;
            cfg_reg.stall_threshold_x16 <= RST_THRESHOLD;
            cfg_reg.settle_ms           <= RST_SETTLE;
            cfg_reg.timeout_ms          <= RST_TIMEOUT;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SAMPLES:   cfg_reg.samples_per_average <= pwdata[7:0];
                REG_ZERO:      cfg_reg.zero_offset_x16     <= pwdata[13:0];
                REG_THRESHOLD: cfg_reg.stall_threshold_x16 <= pwdata[13:0];
                REG_SETTLE:    cfg_reg.settle_ms           <= pwdata[15:0];
                REG_TIMEOUT:   cfg_reg.timeout_ms          <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SAMPLES:   prdata = {24'd0, cfg_reg.samples_per_average};
            REG_ZERO:      prdata = {18'd0, cfg_reg.zero_offset_x16};
            REG_THRESHOLD: prdata = {18'd0, cfg_reg.stall_threshold_x16};
            REG_SETTLE:    prdata = {16'd0, cfg_reg.settle_ms};
            REG_TIMEOUT:   prdata = {16'd0, cfg_reg.timeout_ms};
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== hdl/gsdc_core.sv =====
// Run sequencer and window accumulators of the gripper stall detector.
`timescale 1ns / 1ps

module gsdc_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  gsdc_pkg::op_t  op,
    input  logic [9:0]     adc_sample,
    input  logic           open_request,
    input  gsdc_pkg::cfg_t cfg,
    output gsdc_pkg::res_t res
);
    import gsdc_pkg::*;

    // raw sample sum; offset and threshold are scaled by the count when the window closes
    phase_t             phase_reg,  phase_next;
    logic               dir_reg,    dir_next;
    logic [7:0]         cnt_reg,    cnt_next;
    logic [17:0]        sum_reg,    sum_next;
    logic [15:0]        ms_reg,     ms_next;
    logic               above_reg,  above_next;
    logic               status_reg, status_next;
    logic               done;

    logic [7:0]         win_len;
    logic [7:0]         cnt_inc;
    logic [17:0]        sum_inc;
    logic [21:0]        sum_x16;
    logic [21:0]        centre;
    logic [21:0]        thr_n;
    logic [21:0]        diff_abs;
    logic               win_above;
    logic [15:0]        ms_inc;
    logic               en;

    assign win_len   = (cfg.samples_per_average == 8'd0) ? 8'd1 : cfg.samples_per_average;
    assign cnt_inc   = cnt_reg + 8'd1;
    assign sum_inc   = sum_reg + {8'd0, adc_sample};
    assign sum_x16   = {sum_inc, 4'd0};
    // at most 255 samples, so every product fits in 22 bits
    assign centre    = {8'd0, cfg.zero_offset_x16} * {14'd0, cnt_inc};
    assign thr_n     = {8'd0, cfg.stall_threshold_x16} * {14'd0, cnt_inc};
    assign diff_abs  = (sum_x16 >= centre) ? (sum_x16 - centre) : (centre - sum_x16);
    assign win_above = diff_abs >= thr_n;
    assign ms_inc    = (ms_reg < MS_MAX) ? ms_reg + 16'd1 : ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            dir_reg    <= 1'b0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            ms_reg     <= '0;
            above_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            dir_reg    <= dir_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            ms_reg     <= ms_next;
            above_reg  <= above_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        ms_next     = ms_reg;
        above_next  = above_reg;
        status_next = status_reg;
        done        = 1'b0;

        if (accept)
        begin
            case (op)
                OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        dir_next   = open_request;
                        phase_next = PH_PRE;
                        cnt_next   = '0;
                        sum_next   = '0;
                        ms_next    = '0;
                        above_next = 1'b0;
                    end
                end
                OP_SAMPLE:
                begin
                    if ((phase_reg == PH_PRE) || (phase_reg == PH_MON))
                    begin
                        cnt_next = cnt_inc;
                        sum_next = sum_inc;
                        if (cnt_inc >= win_len)
                        begin
                            cnt_next = '0;
                            sum_next = '0;
                            if (phase_reg == PH_PRE)
                            begin
                                above_next = win_above;
                                phase_next = PH_SETTLE;
                                ms_next    = '0;
                                // no settle time: go straight to monitoring or finish
                                if (cfg.settle_ms == 16'd0)
                                begin
                                    ms_next = '0;
                                    if (win_above)
                                    begin
                                        phase_next  = PH_IDLE;
                                        status_next = 1'b0;
                                        done        = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_MON;
                                    end
                                end
                            end
                            else if (ms_reg > cfg.timeout_ms)
                            begin
                                phase_next  = PH_IDLE;
                                status_next = 1'b1;
                                ms_next     = '0;
                                done        = 1'b1;
                            end
                            else if (win_above)
                            begin
                                phase_next  = PH_IDLE;
                                status_next = 1'b0;
                                ms_next     = '0;
                                done        = 1'b1;
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg == PH_SETTLE)
                    begin
                        ms_next = ms_inc;
                        if (ms_inc >= cfg.settle_ms)
                        begin
                            ms_next = '0;
                            if (above_reg)
                            begin
                                phase_next  = PH_IDLE;
                                status_next = 1'b0;
                                done        = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_MON;
                            end
                        end
                    end
                    else if (phase_reg == PH_MON)
                    begin
                        ms_next = ms_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    assign en = (phase_next == PH_SETTLE) || (phase_next == PH_MON);

    always_comb
    begin
        res.motor_enable = en;
        res.drive_a      = en & ~dir_next;
        res.drive_b      = en & dir_next;
        res.busy_res     = (phase_next != PH_IDLE);
        res.done_res     = done;
        res.status       = status_next;
    end

`ifndef ASSERT_OFF
    a_start_enters_pre: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_START) && (phase_reg == PH_IDLE)) |=> (phase_reg == PH_PRE))
        else $error("start from idle did not begin pre-measure");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (phase_reg == PH_IDLE))
        else $error("finished run left sequencer busy");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> ((cnt_reg == 8'd0) && (sum_reg == 18'd0)
                                    && (ms_reg == 16'd0)))
        else $error("accumulators not cleared while idle");
`endif

endmodule

// ===== hdl/gripper_stall_detect_controller_unit.sv =====
// Top level of the gripper stall detector: stream ports, APB registers, output register.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-------------------------------------
// s_*       | in        | s_tvalid / s_tready        | s_tuser: operation; s_tdata: adc, dir
// m_*       | out       | m_tvalid / m_tready        | m_tdata: motor and run status flags
// APB       | in        | psel / penable, pready = 1 | five config registers at 4*index
//
// One request is taken per clock while s_tready is high; its result is loaded into the output register as it is taken.
// The state update and window test are one pass at the input: an add, two 14x8 products
// and a compare.
// s_tready drops only while a result waits in the output register and m_tready is low.
// rst_n (async, active low) clears the run state, the output valid and the registers
// to their reset values; no clearing pass is needed.
// Register writes, mid-run included, take effect from the next request.

module gripper_stall_detect_controller_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gsdc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gsdc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gsdc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // [9:0] adc_sample, [10] open_request
    input  logic [1:0]                      s_tuser,  // [1:0] operation
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata   // [0] motor_enable, [1] drive_a,
                                                      // [2] drive_b, [3] busy_res,
                                                      // [4] done_res, [5] status
);
    import gsdc_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic m_valid_reg;
    logic accept;

    assign s_tready = ~m_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    gsdc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gsdc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op_t'(s_tuser)),
        .adc_sample   (s_tdata[9:0]),
        .open_request (s_tdata[10]),
        .cfg          (cfg),
        .res          (res)
    );

    // output register: loads on every accepted request, holds while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_reg.status, res_reg.done_res, res_reg.busy_res,
                       res_reg.drive_b, res_reg.drive_a, res_reg.motor_enable};

endmodule

// ===== bench/testbench.sv =====
// Testbench for the gripper stall detector: predicted per-request results checked on the stream.
`timescale 1ns / 1ps

module testbench;

    import gsdc_pkg::*;

    localparam int QUIET_LIMIT = 5000;  // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 80;    // long receiver hold-off

    // ---------------------------------------------------------------- DUT ports
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [9:0] adc_sample, [10] open_request
    logic [1:0]  s_tuser  = '0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] motor_enable .. [5] status

    // ---------------------------------------------------------------- bench state
    int   error_count   = 0;
    int   quiet_cycles  = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_request  = 1'b0;
    int   hold_left     = 0;
    res_t pending_results[$];

    // Predictor copy of the registers and the run state
    cfg_t        cfg_regs;
    phase_t      run_phase;
    logic        run_open;
    logic [7:0]  win_count;
    logic [17:0] win_sum;
    logic [15:0] elapsed_ms;
    logic        pre_above;
    logic        last_timeout;
    logic        run_done;

    gripper_stall_detect_controller_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- predictor
    // A finished run drops to idle, latches its status and clears the window.
    function automatic void close_run(input logic timed_out);
        run_phase    = PH_IDLE;
        last_timeout = timed_out;
        win_count    = '0;
        win_sum      = '0;
        elapsed_ms   = '0;
        run_done     = 1'b1;
    endfunction

    // End of settling: a loud pre-measure window ends the run straight away.
    function automatic void leave_settle();
        if (pre_above)
            close_run(1'b0);
        else
        begin
            run_phase  = PH_MON;
            elapsed_ms = '0;
            win_count  = '0;
            win_sum    = '0;
        end
    endfunction

    function automatic res_t predict_gripper(input op_t op, input logic [9:0] adc,
                                             input logic open_req);
        logic [7:0] win_len;
        logic       hit;
        longint     scaled;
        longint     centre;
        longint     diff;
        res_t       r;
        run_done = 1'b0;
        // a window length of zero behaves as one sample
        win_len = (cfg_regs.samples_per_average == 8'd0) ? 8'd1 : cfg_regs.samples_per_average;
        case (op)
            OP_START:
                if (run_phase == PH_IDLE)
                begin
                    run_open   = open_req;
                    run_phase  = PH_PRE;
                    win_count  = '0;
                    win_sum    = '0;
                    elapsed_ms = '0;
                    pre_above  = 1'b0;
                end
            OP_SAMPLE:
                if (run_phase == PH_PRE || run_phase == PH_MON)
                begin
                    win_sum   = win_sum + 18'(adc);
                    win_count = win_count + 8'd1;
                    if (win_count >= win_len)
                    begin
                        // |16*sum - zero*N| >= threshold*N, all in x16 units
                        scaled = longint'(win_sum) * 16;
                        centre = longint'(cfg_regs.zero_offset_x16) * longint'(win_count);
                        diff   = (scaled >= centre) ? scaled - centre : centre - scaled;
                        hit    = diff >= longint'(cfg_regs.stall_threshold_x16)
                                         * longint'(win_count);
                        win_count = '0;
                        win_sum   = '0;
                        if (run_phase == PH_PRE)
                        begin
                            pre_above  = hit;
                            run_phase  = PH_SETTLE;
                            elapsed_ms = '0;
                            if (cfg_regs.settle_ms == 16'd0)
                                leave_settle();
                        end
                        else if (elapsed_ms > cfg_regs.timeout_ms)
                            close_run(1'b1);   // timeout beats a stall on the same window
                        else if (hit)
                            close_run(1'b0);
                    end
                end
            OP_TICK:
                if (run_phase == PH_SETTLE)
                begin
                    if (elapsed_ms != MS_MAX)
                        elapsed_ms = elapsed_ms + 16'd1;
                    if (elapsed_ms >= cfg_regs.settle_ms)
                        leave_settle();
                end
                else if (run_phase == PH_MON && elapsed_ms != MS_MAX)
                    elapsed_ms = elapsed_ms + 16'd1;
            default: ;
        endcase
        r.motor_enable = (run_phase == PH_SETTLE || run_phase == PH_MON);
        r.drive_a      = r.motor_enable & ~run_open;
        r.drive_b      = r.motor_enable & run_open;
        r.busy_res     = (run_phase != PH_IDLE);
        r.done_res     = run_done;
        r.status       = last_timeout;
        return r;
    endfunction

    // ---------------------------------------------------------------- result checking
    task automatic check_field(input string field_name, input logic want, input logic got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t %s mismatch: expected %b, got %b", $time, field_name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata[5:0]);
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result: expected none, got %b", $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("motor_enable", want.motor_enable, got.motor_enable);
                check_field("drive_a", want.drive_a, got.drive_a);
                check_field("drive_b", want.drive_b, got.drive_b);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("status", want.status, got.status);
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on demand.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: too long without any handshake on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers
    // Offers one request; returns just after the edge that takes it.
    task automatic send_request(input op_t op, input logic [9:0] adc, input logic open_req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, open_req, adc};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_gripper(op, adc, open_req));
    endtask

    // Sender pause until every predicted result has been seen.
    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // APB write then read-back; only ever called with nothing in flight.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        psel     <= 1'b1;
        penable  <= 1'b0;
        pwrite   <= 1'b1;
        paddr    <= {idx, 2'b00};
        pwdata   <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_SAMPLES:   cfg_regs.samples_per_average = value[7:0];
            REG_ZERO:      cfg_regs.zero_offset_x16     = value[13:0];
            REG_THRESHOLD: cfg_regs.stall_threshold_x16 = value[13:0];
            REG_SETTLE:    cfg_regs.settle_ms           = value[15:0];
            REG_TIMEOUT:   cfg_regs.timeout_ms          = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            error_count++;
            $display("%0t register %0d read-back: expected %h, got %h", $time, idx, value, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all_registers(input logic [7:0] n, input logic [13:0] zero,
                                       input logic [13:0] thr, input logic [15:0] settle,
                                       input logic [15:0] timeout);
        write_register(REG_SAMPLES, 32'(n));
        write_register(REG_ZERO, 32'(zero));
        write_register(REG_THRESHOLD, 32'(thr));
        write_register(REG_SETTLE, 32'(settle));
        write_register(REG_TIMEOUT, 32'(timeout));
    endtask

    // ADC level: half uniform, half close to the zero level so both outcomes turn up.
    function automatic logic [9:0] pick_adc();
        int base;
        int spread;
        int v;
        if ($urandom_range(1) == 0)
            return 10'($urandom_range(1023));
        base   = int'(cfg_regs.zero_offset_x16) / 16;
        spread = int'(cfg_regs.stall_threshold_x16) / 16 + 2;
        v      = base - spread + int'($urandom_range(2 * spread));
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return 10'(v);
    endfunction

    // Short windows, settle and timeout keep runs brief; extremes now and then.
    task automatic random_config();
        logic [7:0]  n;
        logic [13:0] zero;
        logic [13:0] thr;
        logic [15:0] settle;
        logic [15:0] timeout;
        n       = ($urandom_range(99) < 8) ? 8'd0 : 8'($urandom_range(8, 1));
        case ($urandom_range(9))
            0:       zero = 14'd0;
            1:       zero = 14'd16368;
            default: zero = 14'($urandom_range(16368));
        endcase
        case ($urandom_range(19))
            0, 1:    thr = 14'd0;
            2:       thr = 14'd16368;
            default: thr = 14'($urandom_range(2400));
        endcase
        settle  = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(6, 1));
        timeout = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(40, 1));
        write_all_registers(n, zero, thr, settle, timeout);
    endtask

    // One request shaped by where the run stands; about a tenth is pure noise.
    task automatic random_request(output bit counted);
        int r;
        r       = $urandom_range(99);
        counted = 1'b1;
        if (r < 10)
        begin
            counted = 1'b0;
            send_request(op_t'($urandom_range(3)), 10'($urandom_range(1023)),
                         1'($urandom_range(1)));
        end
        else
            case (run_phase)
                PH_IDLE:
                    send_request(OP_START, 10'($urandom_range(1023)), 1'($urandom_range(1)));
                PH_PRE:
                    send_request(OP_SAMPLE, pick_adc(), 1'($urandom_range(1)));
                PH_SETTLE:
                    if (r < 90)
                        send_request(OP_TICK, 10'($urandom_range(1023)), 1'($urandom_range(1)));
                    else
                    begin
                        counted = 1'b0;   // sample while settling is dropped
                        send_request(OP_SAMPLE, pick_adc(), 1'($urandom_range(1)));
                    end
                default:
                    if (r < 55 && elapsed_ms <= cfg_regs.timeout_ms && elapsed_ms != MS_MAX)
                        send_request(OP_TICK, 10'($urandom_range(1023)), 1'($urandom_range(1)));
                    else
                        send_request(OP_SAMPLE, pick_adc(), 1'($urandom_range(1)));
            endcase
    endtask

    // Drive the current run to its end (timeout guarantees it with short limits).
    task automatic complete_run();
        while (run_phase != PH_IDLE)
            case (run_phase)
                PH_PRE:    send_request(OP_SAMPLE, pick_adc(), 1'b0);
                PH_SETTLE: send_request(OP_TICK, 10'd0, 1'b0);
                default:
                    if (elapsed_ms <= cfg_regs.timeout_ms && elapsed_ms != MS_MAX)
                        send_request(OP_TICK, 10'd0, 1'b0);
                    else
                        send_request(OP_SAMPLE, pick_adc(), 1'b0);
            endcase
    endtask

    // ---------------------------------------------------------------- tests
    // Reset settings: idle requests change nothing, status reads ok.
    task automatic test_idle_requests();
        send_request(OP_NONE, 10'h3FF, 1'b1);
        send_request(OP_SAMPLE, 10'h3FF, 1'b0);
        send_request(OP_TICK, 10'h000, 1'b1);
        wait_results_drained();
    endtask

    // Close run ending on a stall, then open run whose pre-measure is already loud.
    task automatic test_close_open_runs();
        write_all_registers(8'd2, 14'd8192, 14'd1600, 16'd2, 16'd5);
        send_request(OP_START, 10'd0, 1'b0);
        send_request(OP_START, 10'd0, 1'b1);     // start while busy: dropped
        send_request(OP_TICK, 10'd0, 1'b0);      // tick during pre-measure: dropped
        send_request(OP_SAMPLE, 10'd512, 1'b0);
        send_request(OP_SAMPLE, 10'd512, 1'b0);  // quiet window, into settle
        send_request(OP_SAMPLE, 10'd0, 1'b0);    // sample while settling: dropped
        send_request(OP_NONE, 10'd0, 1'b0);
        send_request(OP_TICK, 10'd0, 1'b0);
        send_request(OP_TICK, 10'd0, 1'b0);      // into monitoring
        send_request(OP_SAMPLE, 10'd1023, 1'b0);
        send_request(OP_SAMPLE, 10'd1023, 1'b0); // stall -> ok
        send_request(OP_START, 10'd0, 1'b1);
        send_request(OP_SAMPLE, 10'd0, 1'b1);
        send_request(OP_SAMPLE, 10'd0, 1'b1);    // loud pre-measure
        send_request(OP_TICK, 10'd0, 1'b1);
        send_request(OP_TICK, 10'd0, 1'b1);      // ends ok when settling ends
        wait_results_drained();
    endtask

    // Window length zero, no settle time, top offset and threshold, timeout winning.
    task automatic test_zero_settle_extremes();
        write_all_registers(8'd0, 14'd16368, 14'd16368, 16'd0, 16'd0);
        send_request(OP_START, 10'd0, 1'b1);
        send_request(OP_SAMPLE, 10'd0, 1'b1);    // loud, settle skipped: done at once
        send_request(OP_START, 10'd0, 1'b0);
        send_request(OP_SAMPLE, 10'd1023, 1'b0); // quiet, straight to monitoring
        send_request(OP_TICK, 10'd0, 1'b0);
        send_request(OP_SAMPLE, 10'd0, 1'b0);    // loud but late: timeout
        wait_results_drained();
    endtask

    task automatic test_random_runs(input int send_pct, input int recv_pct, input int n_items);
        int sent;
        bit counted;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        random_config();
        while (sent < n_items)
        begin
            if (run_phase == PH_IDLE && $urandom_range(11) == 0)
            begin
                wait_results_drained();
                random_config();
            end
            random_request(counted);
            sent += counted;
        end
        complete_run();
        wait_results_drained();
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        bit counted;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        send_request(OP_START, 10'd0, 1'b1);
        hold_request = 1'b1;
        repeat (40) random_request(counted);
        wait_results_drained();
        complete_run();
        wait_results_drained();
    endtask

    // Offset, window length and threshold rewritten part-way through a window.
    task automatic test_midrun_writes();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all_registers(8'd8, 14'd8192, 14'd800, 16'd1, 16'd30);
        send_request(OP_START, 10'd0, 1'b0);
        repeat (8) send_request(OP_SAMPLE, 10'd512, 1'b0);   // quiet pre-measure
        send_request(OP_TICK, 10'd0, 1'b0);                  // into monitoring
        repeat (3) send_request(OP_SAMPLE, 10'd560, 1'b0);   // part of a window
        wait_results_drained();
        write_register(REG_ZERO, 32'd8960);      // zero level moves onto the samples
        write_register(REG_SAMPLES, 32'd2);      // count already past the new length
        send_request(OP_SAMPLE, 10'd560, 1'b0);  // window of four closes, quiet
        send_request(OP_SAMPLE, 10'd560, 1'b0);
        wait_results_drained();
        write_register(REG_THRESHOLD, 32'd0);
        send_request(OP_SAMPLE, 10'd560, 1'b0);  // zero threshold: stall -> ok
        wait_results_drained();
    endtask

    // ---------------------------------------------------------------- sequence
    initial
    begin
        cfg_regs.samples_per_average = RST_SAMPLES;
        cfg_regs.zero_offset_x16     = RST_ZERO;
        cfg_regs.stall_threshold_x16 = RST_THRESHOLD;
        cfg_regs.settle_ms           = RST_SETTLE;
        cfg_regs.timeout_ms          = RST_TIMEOUT;
        run_phase    = PH_IDLE;
        run_open     = 1'b0;
        win_count    = '0;
        win_sum      = '0;
        elapsed_ms   = '0;
        pre_above    = 1'b0;
        last_timeout = 1'b0;
        run_done     = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 49;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_requests();
        test_close_open_runs();
        test_zero_settle_extremes();
        test_random_runs(26, 49, 180);
        test_random_runs(49, 26, 180);
        test_random_runs(0, 0, 180);
        test_output_backpressure();
        test_midrun_writes();

        wait_results_drained();
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gsdc_pkg.sv
hdl/gsdc_regs.sv
hdl/gsdc_core.sv
hdl/gripper_stall_detect_controller_unit.sv
bench/testbench.sv
